### rtl/core/rlp_pkg.sv
// Shared constants, types and state encodings for the run length percentile block.
package rlp_pkg;

    // Default sizing of the run store and of one run length
    localparam int MAX_RUNS_DEF = 1024;
    localparam int LEN_BITS_DEF = 20;

    // Fixed field widths
    localparam int CODE_W    = 4;
    localparam int Q_W       = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_LEN_W = 20;
    localparam int OUT_CNT_W = 11;

    // Register reset values
    localparam logic [CODE_W-1:0] CODE_A_RST = 4'd0;
    localparam logic [CODE_W-1:0] CODE_B_RST = 4'd1;
    localparam logic [CODE_W-1:0] CODE_C_RST = 4'd2;
    localparam logic [Q_W-1:0]    Q_RST      = 16'd62259;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_A = 2'd0,
        REG_CODE_B = 2'd1,
        REG_CODE_C = 2'd2,
        REG_PCT_Q  = 2'd3
    } cfg_reg_e;

    // Selection sequencer states
    typedef enum logic [2:0] {
        SEL_IDLE,
        SEL_INDEX,
        SEL_SCAN,
        SEL_DRAIN,
        SEL_DECIDE,
        SEL_DONE
    } sel_state_t;

    // Status of the selection unit as seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } sel_status_t;

endpackage

### rtl/core/rlp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rlp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register every read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/rlp_select.sv
// Radix select of the k-th smallest stored run length, one bit per pass over the store.
module rlp_select #(
    parameter int MAX_RUNS = rlp_pkg::MAX_RUNS_DEF,
    parameter int LEN_BITS = rlp_pkg::LEN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [$clog2(MAX_RUNS+1)-1:0] count,
    input  logic [rlp_pkg::Q_W-1:0]       q,
    output logic [$clog2(MAX_RUNS)-1:0]   rd_addr,
    input  logic [LEN_BITS-1:0]           rd_data,
    output logic [LEN_BITS-1:0]           result,
    output rlp_pkg::sel_status_t          status
);

    import rlp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RUNS + 1);
    localparam int ADDR_W = $clog2(MAX_RUNS);
    localparam int BIT_W  = $clog2(LEN_BITS);
    localparam int PROD_W = Q_W + CNT_W;

    sel_state_t state_reg, state_next;

    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    tally_reg;
    logic [LEN_BITS-1:0] prefix_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [Q_W-1:0]      q_reg;
    logic                rd_valid_reg;

    logic [PROD_W-1:0]   prod;
    logic [LEN_BITS-1:0] hi_mask;
    logic                match;
    logic                scan_last;

    // Index product q * (n - 1); the fraction bits drop off
    assign prod = PROD_W'(q_reg) * PROD_W'(n_reg - CNT_W'(1));

    // Shared compare: prefix agrees above the current bit and the bit is zero
    assign hi_mask   = ({LEN_BITS{1'b1}} << bit_reg) << 1;
    assign match     = (((rd_data ^ prefix_reg) & hi_mask) == '0) && !rd_data[bit_reg];
    assign scan_last = (addr_reg == (n_reg - CNT_W'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEL_IDLE:
            begin
                if (go)
                begin
                    state_next = (count == '0) ? SEL_DONE : SEL_INDEX;
                end
            end
            SEL_INDEX:  state_next = SEL_SCAN;
            SEL_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = SEL_DRAIN;
                end
            end
            SEL_DRAIN:  state_next = SEL_DECIDE;
            SEL_DECIDE: state_next = (bit_reg == '0) ? SEL_DONE : SEL_SCAN;
            SEL_DONE:   state_next = SEL_IDLE;
            default:    state_next = SEL_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        rd_addr     = addr_reg[ADDR_W-1:0];
        result      = prefix_reg;
        status.busy = (state_reg != SEL_IDLE);
        status.done = (state_reg == SEL_DONE);
    end

    // Advance state, flag read data in the cycle after each issued address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEL_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == SEL_SCAN);
        end
    end

    // Datapath: address sweep, tally, and one prefix bit per pass
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && match)
        begin
            tally_reg <= tally_reg + CNT_W'(1);
        end
        case (state_reg)
            SEL_IDLE:
            begin
                if (go)
                begin
                    n_reg      <= count;
                    q_reg      <= q;
                    prefix_reg <= '0;
                end
            end
            SEL_INDEX:
            begin
                k_reg     <= prod[Q_W +: CNT_W];
                bit_reg   <= BIT_W'(LEN_BITS - 1);
                addr_reg  <= '0;
                tally_reg <= '0;
            end
            SEL_SCAN:
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            SEL_DECIDE:
            begin
                if (k_reg >= tally_reg)
                begin
                    prefix_reg <= prefix_reg | (LEN_BITS'(1) << bit_reg);
                    k_reg      <= k_reg - tally_reg;
                end
                bit_reg   <= bit_reg - BIT_W'(1);
                addr_reg  <= '0;
                tally_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/run_length_percentile.sv
// Top level: run tracking, run store, configuration registers and percentile selection.
//
// Usage: one position per beat on start/busy (accepted when start is high and busy
// is low). Non-final positions never raise busy, so it stays low and a new
// position can follow every cycle. A position with final_item high closes any open
// run and starts the selection; busy then stays high through the result strobe.
// Selection is a radix search over the run store, one bit per pass through the
// memory's single read port; an empty store skips the passes and goes straight
// to the result strobe.
// The result sits on the output ports for the single cycle that done is high; the
// receiver cannot stall, so it must take it then. After the strobe the run count
// and overflow flag clear and the next data set may begin.
// Configuration writes go through cfg_valid/cfg_ready (always ready) and should
// only be issued while busy is low and no position is in flight.
// Reset clears run tracking and restores default intron codes and percentile;
// the run store is not cleared since only written entries are ever read.
module run_length_percentile #(
    parameter int MAX_RUNS = rlp_pkg::MAX_RUNS_DEF,
    parameter int LEN_BITS = rlp_pkg::LEN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rlp_pkg::CODE_W-1:0]    state_code,
    input  logic                          range_end,
    input  logic                          final_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlp_pkg::Q_W-1:0]       cfg_data,
    output logic                          done,
    output logic [rlp_pkg::OUT_LEN_W-1:0] pct_length,
    output logic                          no_runs,
    output logic                          store_overflow,
    output logic [rlp_pkg::OUT_CNT_W-1:0] runs_seen
);

    import rlp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RUNS + 1);
    localparam int ADDR_W = $clog2(MAX_RUNS);
    localparam logic [LEN_BITS-1:0] RUN_MAX = {LEN_BITS{1'b1}};

    logic [CODE_W-1:0]   code_a_reg, code_b_reg, code_c_reg;
    logic [Q_W-1:0]      q_reg;
    logic [LEN_BITS-1:0] cur_reg, cur_next;
    logic                in_run_reg, in_run_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;

    logic                accept;
    logic                body;
    logic [LEN_BITS-1:0] step_cur;
    logic                close_now;
    logic [LEN_BITS-1:0] close_val;
    logic                store_ok;
    logic                wr_en;

    logic [ADDR_W-1:0]   rd_addr;
    logic [LEN_BITS-1:0] rd_data;
    logic [LEN_BITS-1:0] sel_result;
    sel_status_t         sel_status;
    logic [31:0]         len_wide;
    logic [31:0]         cnt_wide;

    assign cfg_ready = 1'b1;
    assign busy      = sel_status.busy;
    assign accept    = start && !busy;

    // Run tracking for one position
    always_comb
    begin
        body = (state_code == code_a_reg) || (state_code == code_b_reg) ||
               (state_code == code_c_reg);
        if (!body)
        begin
            step_cur = cur_reg;
        end
        else if (!in_run_reg)
        begin
            step_cur = LEN_BITS'(1);
        end
        else if (cur_reg != RUN_MAX)
        begin
            step_cur = cur_reg + LEN_BITS'(1);
        end
        else
        begin
            step_cur = cur_reg;
        end
        close_now   = body ? (range_end || final_item) : in_run_reg;
        close_val   = step_cur;
        store_ok    = (count_reg < CNT_W'(MAX_RUNS));
        wr_en       = accept && close_now && store_ok;
        cur_next    = close_now ? '0 : step_cur;
        in_run_next = body && !close_now;
        count_next  = count_reg + CNT_W'(wr_en);
        ovf_next    = ovf_reg || (close_now && !store_ok);
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_a_reg <= CODE_A_RST;
            code_b_reg <= CODE_B_RST;
            code_c_reg <= CODE_C_RST;
            q_reg      <= Q_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_CODE_A: code_a_reg <= cfg_data[CODE_W-1:0];
                REG_CODE_B: code_b_reg <= cfg_data[CODE_W-1:0];
                REG_CODE_C: code_c_reg <= cfg_data[CODE_W-1:0];
                REG_PCT_Q:  q_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance run state per beat, drop the count after the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            in_run_reg <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            cur_reg    <= cur_next;
            in_run_reg <= in_run_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
        else if (sel_status.done)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
    end

    rlp_ram #(
        .WIDTH (LEN_BITS),
        .DEPTH (MAX_RUNS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (close_val),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rlp_select #(
        .MAX_RUNS (MAX_RUNS),
        .LEN_BITS (LEN_BITS)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (accept && final_item),
        .count   (count_next),
        .q       (q_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .result  (sel_result),
        .status  (sel_status)
    );

    // Result beat
    assign len_wide          = 32'(sel_result);
    assign cnt_wide          = 32'(count_reg);
    assign done              = sel_status.done;
    assign pct_length        = len_wide[OUT_LEN_W-1:0];
    assign no_runs           = (count_reg == '0);
    assign store_overflow    = ovf_reg;
    assign runs_seen         = cnt_wide[OUT_CNT_W-1:0];

`ifndef SYNTHESIS
    a_final_starts_select: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && final_item |=> busy)
        else $error("selection did not start after final beat");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("selection did not release after result strobe");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && no_runs |-> pct_length == '0)
        else $error("empty store gave a nonzero length");

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> no_runs && !store_overflow)
        else $error("run count not cleared after result");
`endif

endmodule
